/* rtl/smfr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smfr_pkg: shared constants and tables for the message frame responder
// Framing bytes, command and status codes, parameter table reset image,
// reply signature and programming clock speed maps.
// ----------------------------------------------------------------------------
package smfr_pkg;

  // default frame size limit
  localparam int MAX_FRAME_DEF = 281;

  // parameter table geometry
  localparam int PT_DEPTH = 32;
  localparam int PT_AW    = $clog2(PT_DEPTH);
  localparam int PT_W     = 8;

  // framing bytes
  localparam logic [7:0] START_BYTE = 8'h1B;
  localparam logic [7:0] TOKEN_BYTE = 8'h0E;

  // commands
  localparam logic [7:0] CMD_SIGN_ON   = 8'h01;
  localparam logic [7:0] CMD_SET_PARAM = 8'h02;
  localparam logic [7:0] CMD_GET_PARAM = 8'h03;

  // status codes
  localparam logic [7:0] ST_OK     = 8'h00;
  localparam logic [7:0] ST_FAILED = 8'hC0;
  localparam logic [7:0] ST_CKSUM  = 8'hB0;

  // parameter ids
  localparam logic [7:0] PAR_SCK      = 8'h98;
  localparam logic [7:0] PAR_VTARGET  = 8'h94;

  // speed code after reset
  localparam logic [2:0] SPEED_RESET = 3'd1;

  // result of decoding a clock setting write
  typedef struct packed {
    logic       hit;
    logic [2:0] code;
  } spd_map_t;

  // parameter table contents after reset
  function automatic logic [PT_W-1:0] param_reset(input logic [PT_AW-1:0] addr);
    logic [PT_W-1:0] v;
    v = '0;
    case (addr)
      PT_AW'(16): v = 8'd1;
      PT_AW'(17): v = 8'd2;
      PT_AW'(18): v = 8'd10;
      default:    v = '0;
    endcase
    return v;
  endfunction

  // sign-on signature, eight characters
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] v;
    v = '0;
    case (idx)
      3'd0:    v = "S";
      3'd1:    v = "T";
      3'd2:    v = "K";
      3'd3:    v = "5";
      3'd4:    v = "0";
      3'd5:    v = "0";
      3'd6:    v = "_";
      3'd7:    v = "2";
      default: v = '0;
    endcase
    return v;
  endfunction

  // clock setting value -> speed code
  function automatic spd_map_t speed_from_sck(input logic [7:0] val);
    spd_map_t m;
    m = '{hit: 1'b0, code: 3'd0};
    case (val)
      8'hFE, 8'h4C, 8'h03: m = '{hit: 1'b1, code: 3'd1};
      8'h02:               m = '{hit: 1'b1, code: 3'd2};
      8'h01:               m = '{hit: 1'b1, code: 3'd4};
      8'h00:               m = '{hit: 1'b1, code: 3'd6};
      default:             m = '{hit: 1'b0, code: 3'd0};
    endcase
    return m;
  endfunction

  // speed code -> clock setting value reported on query (code 0 unused)
  function automatic logic [7:0] sck_from_speed(input logic [2:0] spd);
    logic [7:0] v;
    v = '0;
    case (spd)
      3'd1:       v = 8'hFE;
      3'd2, 3'd3: v = 8'h02;
      3'd4, 3'd5: v = 8'h01;
      default:    v = 8'h00;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* rtl/smfr_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smfr_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module smfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/stk_message_frame_responder_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stk_message_frame_responder_unit: serial message frame responder
// Hunts for framed requests in the received byte stream, checks token and
// XOR checksum, and answers each complete frame with a framed reply.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           word
//  in_      input      in_valid/in_stall   rx byte + supply reading
//  out_     output     out_valid/out_stall reply byte + last flag + speed code
//
//  Intake takes one word per cycle. A frame-ending word stalls only while the
//  previous reply is still being sent; other words are taken during a reply.
//  A reply of N bytes (N = 8, 9 or 17) leaves at one word per cycle while not
//  stalled; its first word passes the reply state and output register. The table
//  read (RAM read port) completes before the byte that carries it. Reset clears
//  framing state, head bytes and entry valid bits and sets the speed code
//  to SPEED_RESET; unwritten entries read as their reset image, no clearing pass.
// ----------------------------------------------------------------------------
module stk_message_frame_responder_unit
  import smfr_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic [7:0] in_supply_voltage,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic [7:0] out_tx_byte,
  output      logic       out_last_byte,
  output      logic [2:0] out_sck_code
);

  localparam int POS_W = $clog2(MAX_FRAME + 1);

  // intake state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      exp_r, exp_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [7:0]       head_r [8];
  logic [7:0]       head_nxt [8];
  logic [2:0]       speed_r, speed_nxt;
  logic [PT_DEPTH-1:0] pvalid_r, pvalid_nxt;

  // reply state
  logic             act_r, act_nxt;
  logic [4:0]       idx_r, idx_nxt;
  logic [3:0]       n_r, n_nxt;
  logic [7:0]       rep_r [8];
  logic [7:0]       rep_nxt [8];
  logic [7:0]       sum_r, sum_nxt;
  logic             pend_r, pend_nxt;
  logic [PT_AW-1:0] paddr_r, paddr_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;
  logic [2:0]       out_speed_r, out_speed_nxt;

  // combinational
  logic [POS_W-1:0] p1;
  logic             end_next, busy, acc, fe;
  logic [7:0]       xor_now;
  logic [7:0]       hb [8];
  logic [7:0]       ans [8];
  logic [15:0]      len_now;
  logic [3:0]       ans_n;
  logic             tbl_we, tbl_pend;
  logic [7:0]       tbl_wdata;
  logic [PT_AW-1:0] tbl_addr;
  logic [2:0]       ans_speed;
  spd_map_t         smap;
  logic [7:0]       ram_rdata, rd_val;
  logic             load, is_last;
  logic [4:0]       last_idx;
  logic [7:0]       cur_byte;

  // handshake
  assign p1       = pos_r + 1'b1;
  assign end_next = (pos_r >= POS_W'(5)) && (16'(p1) == exp_r);
  assign busy     = act_r || out_valid_r;
  assign in_stall = end_next && busy;
  assign acc      = in_valid && !in_stall;
  assign xor_now  = xor_r ^ in_rx_byte;
  assign len_now  = {head_r[2], in_rx_byte} + 16'd6;

  // head bytes with the incoming word in place
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hb[i] = (pos_r == POS_W'(i)) ? in_rx_byte : head_r[i];
    end
  end

  // command decode and reply head
  always_comb begin
    ans       = hb;
    ans_n     = 4'd2;
    tbl_we    = 1'b0;
    tbl_pend  = 1'b0;
    tbl_addr  = hb[6][PT_AW-1:0];
    tbl_wdata = hb[7];
    ans_speed = speed_r;
    smap      = speed_from_sck(hb[7]);
    if (xor_now != 8'h00) begin
      ans[5] = ST_CKSUM;
      ans[6] = ST_CKSUM;
      ans_n  = 4'd3;
    end else begin
      case (hb[5])
        CMD_SIGN_ON: begin
          ans[6] = ST_OK;
          ans[7] = 8'd8;
          ans_n  = 4'd11;
        end
        CMD_SET_PARAM: begin
          tbl_we = 1'b1;
          if (hb[6] == PAR_SCK && smap.hit) begin
            ans_speed = smap.code;
          end
          ans[6] = ST_OK;
        end
        CMD_GET_PARAM: begin
          if (hb[6] == PAR_SCK && speed_r != 3'd0) begin
            tbl_we    = 1'b1;
            tbl_wdata = sck_from_speed(speed_r);
            ans[7]    = sck_from_speed(speed_r);
          end else if (hb[6] == PAR_VTARGET) begin
            tbl_we    = 1'b1;
            tbl_wdata = in_supply_voltage;
            ans[7]    = in_supply_voltage;
          end else begin
            tbl_pend  = 1'b1;
          end
          ans[6] = ST_OK;
          ans_n  = 4'd3;
        end
        default: begin
          ans[6] = ST_FAILED;
        end
      endcase
    end
    ans[0] = START_BYTE;
    ans[2] = 8'h00;
    ans[3] = {4'd0, ans_n};
    ans[4] = TOKEN_BYTE;
  end

  // table read result, unwritten entries give the reset image
  assign rd_val = pvalid_r[paddr_r] ? ram_rdata : param_reset(paddr_r);

  // frame intake
  always_comb begin
    pos_nxt  = pos_r;
    exp_nxt  = exp_r;
    xor_nxt  = xor_r;
    head_nxt = head_r;
    fe       = 1'b0;
    if (pend_r) begin
      head_nxt[7] = rd_val;
    end
    if (acc) begin
      if (pos_r == '0) begin
        if (in_rx_byte == START_BYTE) begin
          head_nxt[0] = in_rx_byte;
          pos_nxt     = POS_W'(1);
          xor_nxt     = in_rx_byte;
        end
      end else if (pos_r >= POS_W'(MAX_FRAME)) begin
        pos_nxt = '0;
      end else begin
        head_nxt = hb;
        xor_nxt  = xor_now;
        pos_nxt  = p1;
        if (p1 == POS_W'(4)) begin
          exp_nxt = len_now;
          if (len_now > 16'(MAX_FRAME)) begin
            pos_nxt = '0;
          end
        end else if (p1 == POS_W'(5)) begin
          if (in_rx_byte != TOKEN_BYTE) begin
            pos_nxt = '0;
          end
        end else if (end_next) begin
          pos_nxt  = '0;
          xor_nxt  = 8'h00;
          fe       = 1'b1;
          head_nxt = ans;
        end
      end
    end
  end

  // speed code and table valid bits
  always_comb begin
    speed_nxt  = fe ? ans_speed : speed_r;
    pvalid_nxt = pvalid_r;
    if (fe && tbl_we) begin
      pvalid_nxt[tbl_addr] = 1'b1;
    end
  end

  // parameter table
  smfr_ram #(
    .WIDTH (PT_W),
    .DEPTH (PT_DEPTH)
  ) u_ptab (
    .clk   (clk),
    .we    (fe && tbl_we),
    .waddr (tbl_addr),
    .wdata (tbl_wdata),
    .re    (fe),
    .raddr (tbl_addr),
    .rdata (ram_rdata)
  );

  // reply sequencer
  assign load     = act_r && (!out_valid_r || !out_stall);
  assign last_idx = {1'b0, n_r} + 5'd5;
  assign is_last  = (idx_r == last_idx);
  always_comb begin
    if (is_last) begin
      cur_byte = sum_r;
    end else if (idx_r < 5'd8) begin
      cur_byte = rep_r[idx_r[2:0]];
    end else begin
      cur_byte = sig_byte(idx_r[2:0]);
    end
  end

  always_comb begin
    act_nxt   = act_r;
    idx_nxt   = idx_r;
    n_nxt     = n_r;
    rep_nxt   = rep_r;
    sum_nxt   = sum_r;
    pend_nxt  = 1'b0;
    paddr_nxt = paddr_r;
    if (pend_r) begin
      rep_nxt[7] = rd_val;
    end
    if (fe) begin
      act_nxt   = 1'b1;
      idx_nxt   = '0;
      n_nxt     = ans_n;
      rep_nxt   = ans;
      sum_nxt   = 8'h00;
      pend_nxt  = tbl_pend;
      paddr_nxt = tbl_addr;
    end else if (load) begin
      idx_nxt = idx_r + 5'd1;
      sum_nxt = sum_r ^ cur_byte;
      if (is_last) begin
        act_nxt = 1'b0;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_speed_nxt = out_speed_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cur_byte;
      out_last_nxt  = is_last;
      out_speed_nxt = speed_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tx_byte   = out_byte_r;
  assign out_last_byte = out_last_r;
  assign out_sck_code  = out_speed_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      exp_r       <= '0;
      xor_r       <= '0;
      speed_r     <= SPEED_RESET;
      pvalid_r    <= '0;
      act_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        head_r[i] <= '0;
      end
    end else begin
      pos_r       <= pos_nxt;
      exp_r       <= exp_nxt;
      xor_r       <= xor_nxt;
      speed_r     <= speed_nxt;
      pvalid_r    <= pvalid_nxt;
      act_r       <= act_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    n_r         <= n_nxt;
    rep_r       <= rep_nxt;
    sum_r       <= sum_nxt;
    paddr_r     <= paddr_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    out_speed_r <= out_speed_nxt;
  end

`ifndef SYNTH
  // table read lands while its reply is being sent
  a_pend_in_reply: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> act_r)
    else $error("table read completed outside a reply");

  // reply index never passes the checksum byte
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    act_r |-> (idx_r <= ({1'b0, n_r} + 5'd5)))
    else $error("reply index out of range");

  // nothing follows the checksum byte at once
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r && !out_stall) |=> !out_valid_r)
    else $error("reply word right after checksum");

  // a reply starts only from an accepted word
  a_reply_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(act_r) |-> $past(in_valid && !in_stall))
    else $error("reply started without intake");

  // frame position stays within the frame limit
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(MAX_FRAME))
    else $error("frame position beyond limit");
`endif

endmodule
`default_nettype wire

/* dv/stk_message_frame_responder_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stk_message_frame_responder_unit_tb: self-checking bench for the responder
// Sends request frames byte by byte with random bursts and gaps while the
// reply side stalls on its own pattern. A behavioral copy of the framing and
// command logic predicts every reply word, which is compared field by field.
// A short list of hand-written requests runs first, then random traffic.
// ----------------------------------------------------------------------------
module stk_message_frame_responder_unit_tb
  import smfr_pkg::*;
();

  localparam int MAX_LEN    = MAX_FRAME_DEF;
  localparam int N_WORDS    = 420;
  localparam int WRAP_AFTER = 200;
  localparam int N_REQ_ROWS = 23;

  // command bytes the block does not know
  localparam logic [7:0] CMD_BOGUS = 8'hFF;
  localparam logic [7:0] CMD_NONE  = 8'h00;

  // sign-on reply text, one character per byte
  localparam logic [7:0] SIGNON_TEXT [8] = '{8'h53, 8'h54, 8'h4B, 8'h35,
                                            8'h30, 8'h30, 8'h5F, 8'h32};
  // clock settings that map onto a speed code
  localparam logic [7:0] SCK_VALUES [6] = '{8'hFE, 8'h4C, 8'h03, 8'h02, 8'h01, 8'h00};

  typedef enum logic [1:0] {SEND_STEADY, SEND_SHORT, SEND_LONG} send_mode_t;
  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_CYCLIC} stall_mode_t;

  typedef struct packed {
    logic [7:0] tx;
    logic       last;
    logic [2:0] spd;
  } reply_word_t;

  // one hand-written request; the known_* fields hold a reply read off by eye
  typedef struct packed {
    logic [7:0]  seq;
    logic [15:0] len;
    logic [7:0]  tok;
    logic [7:0]  cmd;
    logic [7:0]  sel;
    logic [7:0]  val;
    logic        sum_ok;
    logic [7:0]  sup;
    logic        known;
    logic [4:0]  known_n;
    logic [7:0]  known_stat;
    logic        known_val_on;
    logic [7:0]  known_val;
  } req_row_t;

  localparam req_row_t REQ_ROWS [N_REQ_ROWS] = '{
    // sign-on, then reads of the reset image and of the clock setting
    '{8'h00, 16'd1, TOKEN_BYTE, CMD_SIGN_ON, 8'h00, 8'h00, 1'b1, 8'h00,
      1'b1, 5'd17, ST_OK, 1'b1, 8'h08},
    '{8'hFF, 16'd2, TOKEN_BYTE, CMD_GET_PARAM, 8'h10, 8'h00, 1'b1, 8'hFF,
      1'b1, 5'd9, ST_OK, 1'b1, 8'h01},
    '{8'h01, 16'd2, TOKEN_BYTE, CMD_GET_PARAM, 8'h12, 8'h00, 1'b1, 8'h00,
      1'b1, 5'd9, ST_OK, 1'b1, 8'h0A},
    '{8'h02, 16'd2, TOKEN_BYTE, CMD_GET_PARAM, PAR_SCK, 8'h00, 1'b1, 8'h00,
      1'b1, 5'd9, ST_OK, 1'b1, 8'hFE},
    // clock setting writes and read-back
    '{8'h03, 16'd3, TOKEN_BYTE, CMD_SET_PARAM, PAR_SCK, 8'h00, 1'b1, 8'h00,
      1'b1, 5'd8, ST_OK, 1'b0, 8'h00},
    '{8'h04, 16'd2, TOKEN_BYTE, CMD_GET_PARAM, PAR_SCK, 8'h00, 1'b1, 8'h00,
      1'b1, 5'd9, ST_OK, 1'b1, 8'h00},
    '{8'h05, 16'd3, TOKEN_BYTE, CMD_SET_PARAM, PAR_SCK, 8'h55, 1'b1, 8'h00,
      1'b1, 5'd8, ST_OK, 1'b0, 8'h00},
    '{8'h06, 16'd2, TOKEN_BYTE, CMD_GET_PARAM, PAR_SCK, 8'h00, 1'b1, 8'h00,
      1'b1, 5'd9, ST_OK, 1'b1, 8'h00},
    // supply reading at both ends
    '{8'h07, 16'd2, TOKEN_BYTE, CMD_GET_PARAM, PAR_VTARGET, 8'h00, 1'b1, 8'hFF,
      1'b1, 5'd9, ST_OK, 1'b1, 8'hFF},
    '{8'h08, 16'd2, TOKEN_BYTE, CMD_GET_PARAM, PAR_VTARGET, 8'h00, 1'b1, 8'h00,
      1'b1, 5'd9, ST_OK, 1'b1, 8'h00},
    // unknown commands
    '{8'h09, 16'd1, TOKEN_BYTE, CMD_BOGUS, 8'h00, 8'h00, 1'b1, 8'h00,
      1'b1, 5'd8, ST_FAILED, 1'b0, 8'h00},
    '{8'h0A, 16'd1, TOKEN_BYTE, CMD_NONE, 8'h00, 8'h00, 1'b1, 8'h00,
      1'b1, 5'd8, ST_FAILED, 1'b0, 8'h00},
    // checksum error
    '{8'h0B, 16'd1, TOKEN_BYTE, CMD_SIGN_ON, 8'h00, 8'h00, 1'b0, 8'h00,
      1'b1, 5'd9, ST_CKSUM, 1'b0, 8'h00},
    // bad token, oversize length: dropped, no reply
    '{8'h0C, 16'd1, 8'h0F, CMD_SIGN_ON, 8'h00, 8'h00, 1'b1, 8'h00,
      1'b1, 5'd0, ST_OK, 1'b0, 8'h00},
    '{8'h0D, 16'd1, 8'hFF, CMD_SIGN_ON, 8'h00, 8'h00, 1'b1, 8'h00,
      1'b1, 5'd0, ST_OK, 1'b0, 8'h00},
    '{8'h0E, 16'd276, TOKEN_BYTE, CMD_SIGN_ON, 8'h00, 8'h00, 1'b1, 8'h00,
      1'b1, 5'd0, ST_OK, 1'b0, 8'h00},
    '{8'h0F, 16'hFF00, TOKEN_BYTE, CMD_SIGN_ON, 8'h00, 8'h00, 1'b1, 8'h00,
      1'b1, 5'd0, ST_OK, 1'b0, 8'h00},
    // short bodies: operands come from stale head bytes
    '{8'h10, 16'd0, TOKEN_BYTE, CMD_NONE, 8'h00, 8'h00, 1'b1, 8'h00,
      1'b0, 5'd0, ST_OK, 1'b0, 8'h00},
    '{8'h11, 16'd1, TOKEN_BYTE, CMD_SET_PARAM, 8'h00, 8'h00, 1'b1, 8'h00,
      1'b0, 5'd0, ST_OK, 1'b0, 8'h00},
    // table index wraps on the low five bits
    '{8'h12, 16'd3, TOKEN_BYTE, CMD_SET_PARAM, 8'h30, 8'hA5, 1'b1, 8'h00,
      1'b1, 5'd8, ST_OK, 1'b0, 8'h00},
    '{8'h13, 16'd2, TOKEN_BYTE, CMD_GET_PARAM, 8'h10, 8'h00, 1'b1, 8'h00,
      1'b1, 5'd9, ST_OK, 1'b1, 8'hA5},
    '{8'h14, 16'd3, TOKEN_BYTE, CMD_SET_PARAM, PAR_SCK, 8'h02, 1'b1, 8'h00,
      1'b1, 5'd8, ST_OK, 1'b0, 8'h00},
    '{8'h15, 16'd2, TOKEN_BYTE, CMD_GET_PARAM, PAR_SCK, 8'h00, 1'b1, 8'h00,
      1'b1, 5'd9, ST_OK, 1'b1, 8'h02}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic [7:0] in_supply_voltage = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_tx_byte;
  logic       out_last_byte;
  logic [2:0] out_sck_code;

  stk_message_frame_responder_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .in_supply_voltage (in_supply_voltage),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tx_byte       (out_tx_byte),
    .out_last_byte     (out_last_byte),
    .out_sck_code      (out_sck_code)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Behavioral copy of the responder
  // ---------------------------------------------------------------------------
  logic [8:0]  frame_pos;
  logic [15:0] frame_span;
  logic [7:0]  frame_sum;
  logic [7:0]  head [8];
  logic [7:0]  params [32];
  logic [2:0]  speed;
  reply_word_t pending_reply [$];

  function automatic void model_reset();
    int i;
    frame_pos  = '0;
    frame_span = '0;
    frame_sum  = '0;
    for (i = 0; i < 8; i++) head[i] = '0;
    for (i = 0; i < 32; i++) params[i] = '0;
    params[16] = 8'd1;
    params[17] = 8'd2;
    params[18] = 8'd10;
    speed = SPEED_RESET;
  endfunction

  // build the reply for a completed frame and queue its words
  function automatic void compose_reply(input logic [7:0] sup);
    logic [7:0] sel;
    logic [7:0] val;
    logic [7:0] n;
    logic [7:0] cks;
    logic [7:0] b;
    int         i;
    sel = head[6];
    val = head[7];
    n   = 8'd2;
    cks = '0;
    if (frame_sum != 8'h00) begin
      head[5] = ST_CKSUM;
      head[6] = ST_CKSUM;
      n = 8'd3;
    end else if (head[5] == CMD_SIGN_ON) begin
      head[6] = ST_OK;
      head[7] = 8'd8;
      n = 8'd11;
    end else if (head[5] == CMD_SET_PARAM) begin
      params[sel[4:0]] = val;
      if (sel == PAR_SCK) begin
        case (val)
          8'hFE, 8'h4C, 8'h03: speed = 3'd1;
          8'h02:               speed = 3'd2;
          8'h01:               speed = 3'd4;
          8'h00:               speed = 3'd6;
          default:             ;
        endcase
      end
      head[6] = ST_OK;
    end else if (head[5] == CMD_GET_PARAM) begin
      if (sel == PAR_SCK) begin
        case (speed)
          3'd1:       params[PAR_SCK[4:0]] = 8'hFE;
          3'd2, 3'd3: params[PAR_SCK[4:0]] = 8'h02;
          3'd4, 3'd5: params[PAR_SCK[4:0]] = 8'h01;
          3'd6, 3'd7: params[PAR_SCK[4:0]] = 8'h00;
          default:    ;
        endcase
      end else if (sel == PAR_VTARGET) begin
        params[PAR_VTARGET[4:0]] = sup;
      end
      head[7] = params[sel[4:0]];
      head[6] = ST_OK;
      n = 8'd3;
    end else begin
      head[6] = ST_FAILED;
    end
    head[0] = START_BYTE;
    head[2] = 8'h00;
    head[3] = n;
    head[4] = TOKEN_BYTE;
    for (i = 0; i < 5 + int'(n); i++) begin
      b = (i < 8) ? head[i] : SIGNON_TEXT[(i - 8) & 7];
      cks ^= b;
      pending_reply.push_back(reply_word_t'{tx: b, last: 1'b0, spd: speed});
    end
    pending_reply.push_back(reply_word_t'{tx: cks, last: 1'b1, spd: speed});
  endfunction

  // one received byte through the framer
  function automatic void frame_intake(input logic [7:0] b, input logic [7:0] sup);
    if (frame_pos == 0) begin
      if (b == START_BYTE) begin
        head[0]   = b;
        frame_pos = 9'd1;
        frame_sum = b;
      end
      return;
    end
    if (frame_pos >= MAX_LEN) begin
      frame_pos = '0;
      return;
    end
    if (frame_pos < 8) head[frame_pos[2:0]] = b;
    frame_pos++;
    frame_sum ^= b;
    if (frame_pos == 4) begin
      frame_span = {head[2], head[3]} + 16'd6;
      if (frame_span > MAX_LEN) frame_pos = '0;
      return;
    end
    if (frame_pos == 5) begin
      if (b != TOKEN_BYTE) frame_pos = '0;
      return;
    end
    if (frame_pos == frame_span) begin
      frame_pos = '0;
      compose_reply(sup);
      frame_sum = '0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting
  // ---------------------------------------------------------------------------
  int errors = 0;

  task automatic flag_error(input string what);
    errors++;
    if (errors <= 40) $display("ERROR @%0t: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // Intake tracking and reply checking
  // ---------------------------------------------------------------------------
  reply_word_t want;
  logic [7:0]  got_bytes [32];
  int          got_run = 0;
  int          got_len = 0;
  int          replies_seen = 0;
  int          words_checked = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      model_reset();
    end else begin
      if (in_valid && !in_stall) frame_intake(in_rx_byte, in_supply_voltage);
      if (out_valid && !out_stall) begin
        if (pending_reply.size() == 0) begin
          flag_error($sformatf("reply word %02h with nothing pending", out_tx_byte));
        end else begin
          want = pending_reply.pop_front();
          if (out_tx_byte !== want.tx)
            flag_error($sformatf("tx_byte %02h, want %02h", out_tx_byte, want.tx));
          if (out_last_byte !== want.last)
            flag_error($sformatf("last_byte %0b, want %0b", out_last_byte, want.last));
          if (out_sck_code !== want.spd)
            flag_error($sformatf("sck_code %0d, want %0d", out_sck_code, want.spd));
          words_checked++;
        end
        if (got_run < 32) got_bytes[got_run] = out_tx_byte;
        got_run++;
        if (out_last_byte === 1'b1) begin
          got_len = got_run;
          got_run = 0;
          replies_seen++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Reply side stall pattern
  // ---------------------------------------------------------------------------
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_hold = 0;
  logic [7:0]  stall_tick = '0;

  always @(posedge clk) begin
    stall_tick <= stall_tick + 8'd1;
    if (stall_hold == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_hold <= $urandom_range(16, 160);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_tick[2:0] < 3'd3);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  send_mode_t send_mode = SEND_STEADY;
  int         burst_left = 0;
  int         words_sent = 0;

  // present one word, with a random gap between bursts unless sending steadily, and wait for it
  task automatic put_word(input logic [7:0] b, input logic [7:0] sup);
    int gap;
    if (burst_left == 0) begin
      if (send_mode != SEND_STEADY) begin
        gap = (send_mode == SEND_SHORT) ? $urandom_range(1, 3) : $urandom_range(4, 30);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid          <= 1'b1;
    in_rx_byte        <= b;
    in_supply_voltage <= sup;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // build a request frame and send it, less 'cut' trailing words
  task automatic send_frame(input logic [7:0] seq, input logic [15:0] len,
                            input logic [7:0] tok, input logic [7:0] cmd,
                            input logic [7:0] sel, input logic [7:0] val,
                            input bit sum_ok, input logic [7:0] sup,
                            input int cut);
    logic [7:0]  fb [$];
    logic [15:0] span;
    logic [7:0]  x;
    int          i;
    fb   = {START_BYTE, seq, len[15:8], len[7:0]};
    span = len + 16'd6;
    if (span <= MAX_LEN) begin
      fb.push_back(tok);
      if (tok == TOKEN_BYTE) begin
        if (span < 16'd6) begin
          // length wrapped: fills to the size limit, one more word is dropped
          for (i = 0; i < MAX_LEN - 4; i++) fb.push_back(8'($urandom));
        end else begin
          for (i = 0; i < int'(len); i++)
            fb.push_back(i == 0 ? cmd : i == 1 ? sel : i == 2 ? val : 8'($urandom));
          x = 8'h00;
          for (i = 0; i < fb.size(); i++) x ^= fb[i];
          fb.push_back(sum_ok ? x : x ^ 8'($urandom_range(1, 255)));
        end
      end
    end
    for (i = 0; i < fb.size() - cut; i++) put_word(fb[i], sup);
  endtask

  initial begin
    req_row_t    row;
    int          seen0;
    int          roll;
    int          cut;
    bit          sum_ok;
    bit          wrap_done;
    logic [7:0]  seq;
    logic [7:0]  sup;
    logic [7:0]  cmd;
    logic [7:0]  sel;
    logic [7:0]  val;
    logic [7:0]  tok;
    logic [7:0]  b;
    logic [15:0] len;
    wrap_done = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // line noise while hunting, field extremes
    put_word(8'h00, 8'h00);
    put_word(8'hFF, 8'hFF);
    put_word(TOKEN_BYTE, 8'h5A);

    // hand-written requests, each drained before the next
    for (int r = 0; r < N_REQ_ROWS; r++) begin
      row       = REQ_ROWS[r];
      send_mode = send_mode_t'($urandom_range(0, 2));
      seen0     = replies_seen;
      send_frame(row.seq, row.len, row.tok, row.cmd, row.sel, row.val, row.sum_ok,
                 row.sup, 0);
      in_valid <= 1'b0;
      @(posedge clk);
      while (pending_reply.size() != 0) @(posedge clk);
      if (row.known) begin
        if (row.known_n == 0) begin
          if (replies_seen != seen0) flag_error($sformatf("request %0d: reply to a drop", r));
        end else if (replies_seen != seen0 + 1 || got_len != int'(row.known_n) ||
                     got_bytes[6] !== row.known_stat ||
                     (row.known_val_on && got_bytes[7] !== row.known_val)) begin
          flag_error($sformatf("request %0d: reply len %0d status %02h value %02h",
                               r, got_len, got_bytes[6], got_bytes[7]));
        end
      end
    end

    // random traffic up to the word budget
    while (words_sent < N_WORDS) begin
      send_mode = ($urandom_range(0, 3) == 0) ? SEND_LONG : send_mode_t'($urandom_range(0, 1));
      roll = $urandom_range(0, 99);
      seq  = 8'($urandom);
      sup  = ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom);
      if (!wrap_done && words_sent >= WRAP_AFTER) begin
        // one frame whose length wraps below the header size
        wrap_done = 1'b1;
        send_frame(seq, 16'($urandom_range(16'hFFFA, 16'hFFFF)), TOKEN_BYTE, CMD_SIGN_ON,
                   8'h00, 8'h00, 1'b1, sup, 0);
      end else if (roll < 8) begin
        // noise between frames
        repeat ($urandom_range(1, 4)) begin
          b = 8'($urandom);
          if (b == START_BYTE) b = ~b;
          put_word(b, sup);
        end
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: cmd = CMD_SIGN_ON;
          3, 4, 5: cmd = CMD_SET_PARAM;
          6, 7, 8: cmd = CMD_GET_PARAM;
          default: cmd = 8'($urandom);
        endcase
        case ($urandom_range(0, 5))
          0, 1:    sel = PAR_SCK;
          2:       sel = PAR_VTARGET;
          3:       sel = 8'($urandom_range(0, 31));
          default: sel = 8'($urandom);
        endcase
        val = ($urandom_range(0, 2) == 0) ? 8'($urandom) : SCK_VALUES[$urandom_range(0, 5)];
        if (cmd == CMD_SIGN_ON)        len = 16'd1;
        else if (cmd == CMD_SET_PARAM) len = 16'd3;
        else if (cmd == CMD_GET_PARAM) len = 16'd2;
        else                           len = 16'($urandom_range(1, 3));
        if ($urandom_range(0, 7) == 0)      len = 16'($urandom_range(0, 3));
        else if ($urandom_range(0, 9) == 0) len = len + 16'($urandom_range(1, 8));
        tok    = TOKEN_BYTE;
        sum_ok = 1'b1;
        cut    = 0;
        if (roll < 14)      tok = 8'($urandom);
        else if (roll < 20) sum_ok = 1'b0;
        else if (roll < 24) len = 16'($urandom_range(MAX_LEN - 5, 16'hFFF9));
        else if (roll < 28) cut = $urandom_range(1, 3);
        send_frame(seq, len, tok, cmd, sel, val, sum_ok, sup, cut);
      end
    end

    // drain and let the block settle
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reply.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("run covered %0d request words and %0d reply words in %0d replies",
             words_sent, words_checked, replies_seen);
    $display("mismatches: %0d", errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
